[src/acsq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed command staging queue package
// Shared sizes, request/result/job types, command and status codes and small
// helpers used by the front, the job queue, the back and the top level.
// ----------------------------------------------------------------------------
package acsq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PAYLOAD_WIDTH = 64;

   localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int QCOUNT_W = 5;

   typedef enum logic [3:0] {
      CMD_QUEUE       = 4'd0,
      CMD_ARM         = 4'd1,
      CMD_START       = 4'd2,
      CMD_START_AT    = 4'd3,
      CMD_CLEAR       = 4'd4,
      CMD_ESTOP       = 4'd5,
      CMD_CLEAR_FAULT = 4'd6,
      CMD_MOTION_DONE = 4'd7,
      CMD_FAULT       = 4'd8,
      CMD_TICK        = 4'd9
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_INVALID = 3'd3,
      ST_EXPIRED = 3'd4
   } status_type;

   // Controller state, held one-hot.
   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_ARMED   = 5'b00010,
      MODE_RUNNING = 5'b00100,
      MODE_FAULT   = 5'b01000,
      MODE_ESTOP   = 5'b10000
   } mode_type;

   // Controller state as reported on the result channel.
   localparam logic [2:0] CODE_IDLE    = 3'd0;
   localparam logic [2:0] CODE_ARMED   = 3'd1;
   localparam logic [2:0] CODE_RUNNING = 3'd2;
   localparam logic [2:0] CODE_FAULT   = 3'd3;
   localparam logic [2:0] CODE_ESTOP   = 3'd4;

   typedef enum logic [1:0] {
      JOB_SINGLE    = 2'd0,
      JOB_DRAIN     = 2'd1,
      JOB_HARD_STOP = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [63:0] payload;
      logic [31:0] target_tick;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  ctrl_state;
      logic [4:0]  queued_count;
      logic        send_valid;
      logic [63:0] send_payload;
      logic        send_hard_stop;
      logic        last;
   } rsp_type;

   // Work handed from the front to the back.
   typedef struct packed {
      job_kind_type     kind;
      logic [2:0]       status;
      logic [2:0]       ctrl_state;
      logic [CNT_W-1:0] count;
      logic [PTR_W-1:0] rd_ptr;
   } job_type;

   function automatic logic [2:0] mode_code(mode_type mode);
      logic [2:0] code;
      unique case (mode)
         MODE_IDLE:    code = CODE_IDLE;
         MODE_ARMED:   code = CODE_ARMED;
         MODE_RUNNING: code = CODE_RUNNING;
         MODE_FAULT:   code = CODE_FAULT;
         MODE_ESTOP:   code = CODE_ESTOP;
         default:      code = CODE_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   function automatic logic [QCOUNT_W-1:0] to_qcount(logic [CNT_W-1:0] cnt);
      logic [QCOUNT_W+CNT_W-1:0] wide;
      wide = (QCOUNT_W + CNT_W)'(cnt);
      return wide[QCOUNT_W-1:0];
   endfunction

endpackage

[src/acsq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module acsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/acsq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staging queue front
// Decodes each accepted request against the controller state, keeps the ring
// pointers, tick counter and delayed start, writes queued words into the
// ring and hands one job per request to the back.
// ----------------------------------------------------------------------------
module acsq_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  acsq_pkg::req_type                     req,
   output logic                                  push,
   output acsq_pkg::job_type                     push_job,
   output logic                                  wr_en,
   output logic [acsq_pkg::PTR_W-1:0]            wr_addr,
   output logic [acsq_pkg::PAYLOAD_WIDTH-1:0]    wr_data
);
   import acsq_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [31:0]      tick_ff, tick_in;
   logic             pend_ff, pend_in;
   logic [31:0]      pend_tick_ff, pend_tick_in;

   logic [31:0] start_diff;
   logic [31:0] tick_next;
   logic [31:0] fire_diff;
   logic        do_drain;
   logic        ring_full;

   assign start_diff = req.target_tick - tick_ff;
   assign tick_next  = tick_ff + 32'd1;
   assign fire_diff  = pend_tick_ff - tick_next;
   assign ring_full  = (held_ff >= CNT_W'(QUEUE_DEPTH));

   assign wr_addr = wr_ptr_ff;
   assign wr_data = req.payload[PAYLOAD_WIDTH-1:0];
   assign push    = accept;

   always_comb begin
      mode_in           = mode_ff;
      rd_ptr_in         = rd_ptr_ff;
      wr_ptr_in         = wr_ptr_ff;
      held_in           = held_ff;
      tick_in           = tick_ff;
      pend_in           = pend_ff;
      pend_tick_in      = pend_tick_ff;
      do_drain          = 1'b0;
      wr_en             = 1'b0;
      push_job.kind     = JOB_SINGLE;
      push_job.status   = ST_OK;
      push_job.rd_ptr   = rd_ptr_ff;

      if (accept) begin
         unique case (req.cmd)
            CMD_QUEUE: begin
               if (mode_ff != MODE_IDLE) begin
                  push_job.status = ST_INVALID;
               end else if (ring_full) begin
                  push_job.status = ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  wr_ptr_in = next_ptr(wr_ptr_ff);
                  held_in   = held_ff + CNT_W'(1);
               end
            end
            CMD_ARM: begin
               if (mode_ff != MODE_IDLE) begin
                  push_job.status = ST_INVALID;
               end else if (held_ff == '0) begin
                  push_job.status = ST_EMPTY;
               end else begin
                  mode_in = MODE_ARMED;
               end
            end
            CMD_START: begin
               if (mode_ff == MODE_ARMED) begin
                  do_drain = 1'b1;
               end else begin
                  push_job.status = ST_INVALID;
               end
            end
            CMD_START_AT: begin
               if (mode_ff != MODE_ARMED) begin
                  push_job.status = ST_INVALID;
               end else if (start_diff[31]) begin
                  push_job.status = ST_EXPIRED;
               end else if (start_diff == 32'd0) begin
                  do_drain = 1'b1;
               end else begin
                  pend_in      = 1'b1;
                  pend_tick_in = req.target_tick;
               end
            end
            CMD_CLEAR: begin
               if (mode_ff == MODE_RUNNING) begin
                  push_job.status = ST_INVALID;
               end else begin
                  rd_ptr_in = '0;
                  wr_ptr_in = '0;
                  held_in   = '0;
                  if (mode_ff != MODE_FAULT && mode_ff != MODE_ESTOP) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
            CMD_ESTOP: begin
               rd_ptr_in     = '0;
               wr_ptr_in     = '0;
               held_in       = '0;
               mode_in       = MODE_ESTOP;
               push_job.kind = JOB_HARD_STOP;
            end
            CMD_CLEAR_FAULT: begin
               if (mode_ff != MODE_FAULT && mode_ff != MODE_ESTOP) begin
                  push_job.status = ST_INVALID;
               end else begin
                  rd_ptr_in = '0;
                  wr_ptr_in = '0;
                  held_in   = '0;
                  mode_in   = MODE_IDLE;
               end
            end
            CMD_MOTION_DONE: begin
               if (mode_ff == MODE_RUNNING) begin
                  mode_in = MODE_IDLE;
               end
            end
            CMD_FAULT: begin
               mode_in = MODE_FAULT;
            end
            CMD_TICK: begin
               tick_in = tick_next;
               if (pend_ff && (fire_diff == 32'd0 || fire_diff[31])) begin
                  pend_in = 1'b0;
                  if (mode_ff == MODE_ARMED) begin
                     do_drain = 1'b1;
                  end else begin
                     push_job.status = ST_INVALID;
                  end
               end
            end
            default: begin
               push_job.status = ST_INVALID;
            end
         endcase
      end

      // A drain of an empty ring is a single ok result with nothing sent.
      if (do_drain) begin
         mode_in = MODE_RUNNING;
         if (held_ff != '0) begin
            push_job.kind = JOB_DRAIN;
            rd_ptr_in     = wr_ptr_ff;
            held_in       = '0;
         end
      end

      push_job.ctrl_state = mode_code(mode_in);
      push_job.count      = (push_job.kind == JOB_DRAIN) ? held_ff : held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         tick_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_tick_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         held_ff      <= held_in;
         tick_ff      <= tick_in;
         pend_ff      <= pend_in;
         pend_tick_ff <= pend_tick_in;
      end
   end

endmodule

[src/acsq_job_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staging queue job FIFO
// Two-entry queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module acsq_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  acsq_pkg::job_type push_job,
   input  logic              pop,
   output acsq_pkg::job_type pop_job,
   output logic              not_empty
);
   import acsq_pkg::*;

   job_type    slot_ff [2];
   logic       wr_sel_ff;
   logic       rd_sel_ff;
   logic [1:0] fill_ff;
   logic       do_push;
   logic       do_pop;

   assign not_empty = (fill_ff != 2'd0);
   assign do_pop    = pop && not_empty;
   assign do_push   = push && (fill_ff != 2'd2);
   assign pop_job   = slot_ff[rd_sel_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_sel_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_sel_ff <= ~wr_sel_ff;
         end
         if (do_pop) begin
            rd_sel_ff <= ~rd_sel_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

[src/acsq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staging queue back
// Takes jobs from the FIFO and produces results: one result for a simple
// job, or one result per ring entry for a drain, reading the ring a word a
// cycle.
// ----------------------------------------------------------------------------
module acsq_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  acsq_pkg::job_type                  job,
   output logic                               pop,
   output logic                               rd_en,
   output logic [acsq_pkg::PTR_W-1:0]         rd_addr,
   input  logic [acsq_pkg::PAYLOAD_WIDTH-1:0] rd_data,
   output logic                               rsp_strobe,
   output acsq_pkg::rsp_type                  rsp_item,
   output logic                               busy
);
   import acsq_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'b01,
      BK_DRAIN = 2'b10
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             out_valid_ff, out_valid_in;
   logic             use_ram_ff, use_ram_in;
   rsp_type          out_ff, out_in;
   logic [CNT_W-1:0] left_dec;

   assign left_dec = left_ff - CNT_W'(1);
   assign rd_addr  = ptr_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      out_valid_in = 1'b0;
      use_ram_in   = 1'b0;
      out_in       = out_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               pop = 1'b1;
               out_in.status         = job.status;
               out_in.ctrl_state     = job.ctrl_state;
               out_in.queued_count   = to_qcount(job.count);
               out_in.send_valid     = 1'b0;
               out_in.send_payload   = '0;
               out_in.send_hard_stop = 1'b0;
               out_in.last           = 1'b1;
               unique case (job.kind)
                  JOB_DRAIN: begin
                     state_in = BK_DRAIN;
                     ptr_in   = job.rd_ptr;
                     left_in  = job.count;
                  end
                  JOB_HARD_STOP: begin
                     out_valid_in          = 1'b1;
                     out_in.send_valid     = 1'b1;
                     out_in.send_hard_stop = 1'b1;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         BK_DRAIN: begin
            // The read issued now lands in the RAM output register together
            // with the result fields registered here.
            rd_en                 = 1'b1;
            out_valid_in          = 1'b1;
            use_ram_in            = 1'b1;
            out_in.status         = ST_OK;
            out_in.ctrl_state     = CODE_RUNNING;
            out_in.queued_count   = to_qcount(left_dec);
            out_in.send_valid     = 1'b1;
            out_in.send_payload   = '0;
            out_in.send_hard_stop = 1'b0;
            out_in.last           = (left_dec == '0);
            ptr_in                = next_ptr(ptr_ff);
            left_in               = left_dec;
            if (left_dec == '0) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         use_ram_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         use_ram_ff   <= use_ram_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      out_ff  <= out_in;
   end

   always_comb begin
      rsp_item = out_ff;
      if (use_ram_ff) begin
         rsp_item.send_payload = 64'(rd_data);
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign busy       = (state_ff != BK_IDLE) || out_valid_ff;

endmodule

[src/armed_command_staging_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed command staging queue
// Motion command staging ring with an idle / armed / running / fault /
// emergency-stop controller, immediate and tick-timed starts.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. Every
// request produces at least one result on rsp_item, each shown for exactly
// one cycle with rsp_strobe high; the result side has no back pressure, so a
// receiver must take every strobed result. The final result of a request
// carries last. A simple request (queue, arm, clear, fault, a tick with
// nothing to fire, and so on) gives one result, which passes through the
// job FIFO and the result register of the back, and busy stays high until
// that result has been shown. A start that drains the ring gives one send
// result per stored command on consecutive cycles; the first passes the
// job FIFO, the back's drain state and the registered ring read. A start
// on an empty ring gives a single result and is timed like a simple
// request. The drain rate is set by the single read port of the command
// ring, which yields one stored word per cycle. The controller state, ring
// pointers and tick counter are updated when the request is taken, so the
// state reported in the results is the one that the request leaves behind.
// ----------------------------------------------------------------------------
module armed_command_staging_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  acsq_pkg::req_type req_item,
   output logic              rsp_strobe,
   output acsq_pkg::rsp_type rsp_item
);
   import acsq_pkg::*;

   logic                     accept;
   logic                     push;
   job_type                  push_job;
   job_type                  pop_job;
   logic                     pop;
   logic                     job_valid;
   logic                     back_busy;
   logic                     wr_en;
   logic [PTR_W-1:0]         wr_addr;
   logic [PAYLOAD_WIDTH-1:0] wr_data;
   logic                     rd_en;
   logic [PTR_W-1:0]         rd_addr;
   logic [PAYLOAD_WIDTH-1:0] rd_data;

   // Only one request is in flight at a time: the ring is written by the
   // front and read by the back, and a drain must see the ring as it was
   // when its start was taken.
   assign busy   = job_valid || back_busy;
   assign accept = start && !busy;

   // The front decodes the request and owns all controller state.
   acsq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_item),
      .push     (push),
      .push_job (push_job),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   // Command ring storage.
   acsq_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Jobs wait here until the back is free.
   acsq_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (job_valid)
   );

   // The back turns each job into its results.
   acsq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (pop_job),
      .pop        (pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .busy       (back_busy)
   );

   // A taken request always leaves the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("busy low right after a request was taken");

   // No new request may be taken while a result is being shown.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result shown while the block reports idle");

   // The results of a drain come out on consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |=> rsp_strobe)
      else $error("gap inside a run of drain results");

   // A hard stop is a single result and leaves the controller stopped.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.send_hard_stop) |->
         (rsp_item.last && rsp_item.ctrl_state == CODE_ESTOP
          && rsp_item.queued_count == '0))
      else $error("hard stop result with wrong state or queue count");

endmodule

[tb/armed_command_staging_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed command staging queue testbench
// Drives command requests into the staging queue and checks every strobed
// result, field by field and in order, against a typed expected value or
// a cycle-free behavioral model of the controller, command ring and tick-timed start.
// ----------------------------------------------------------------------------
module armed_command_staging_queue_tb;

   import acsq_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 2;
   // A short tail is enough to catch any stray result once nothing is awaited.
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT_NS  = 2_000_000;
   localparam int PHASE_ITEMS   = 80;

   // Top of the unused command codes; the block answers it with an invalid status.
   localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   armed_command_staging_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Model of the block. The state below mirrors the controller, the ring and
   // the tick counter as they stand after every request taken so far.
   // -------------------------------------------------------------------------
   logic [63:0]      ring_words [QUEUE_DEPTH];
   logic [PTR_W-1:0] ring_rd             = '0;
   logic [PTR_W-1:0] ring_wr             = '0;
   logic [CNT_W-1:0] ring_held           = '0;
   logic [2:0]       ctl_mode            = CODE_IDLE;
   logic [31:0]      ctl_tick            = '0;
   logic             timed_start_pending = 1'b0;
   logic [31:0]      timed_start_tick    = '0;

   // Results caused by the request just modeled, and every result still owed
   // by the block, oldest first.
   rsp_type staged_results [$];
   rsp_type awaited_results [$];
   rsp_type awaited_head;

   int error_count     = 0;
   int requests_sent   = 0;
   int sender_idle_pct = 0;

   typedef struct {
      logic [3:0]  cmd;
      logic [63:0] payload;
      logic [31:0] target;
      bit          typed;
      rsp_type     want;
   } step_row_type;

   step_row_type script [$];

   function automatic rsp_type plain_result(logic [2:0] st, logic [2:0] mode,
                                            logic [4:0] count);
      rsp_type r;
      r = '0;
      r.status       = st;
      r.ctrl_state   = mode;
      r.queued_count = count;
      r.last         = 1'b1;
      return r;
   endfunction

   function automatic logic [4:0] to_count(logic [CNT_W-1:0] held);
      return 5'(held);
   endfunction

   // Results report the state that the request leaves behind, so a result is
   // recorded only after the state it describes has been updated.
   task automatic record_result(input logic [2:0] st, input logic valid,
                                input logic [63:0] word, input logic hard,
                                input logic last);
      rsp_type r;
      r.status         = st;
      r.ctrl_state     = ctl_mode;
      r.queued_count   = to_count(ring_held);
      r.send_valid     = valid;
      r.send_payload   = valid ? word : '0;
      r.send_hard_stop = hard;
      r.last           = last;
      staged_results.push_back(r);
   endtask

   task automatic flush_ring();
      ring_rd   = '0;
      ring_wr   = '0;
      ring_held = '0;
   endtask

   // A start sends every held command in ring order and leaves the
   // controller running. An empty ring still gives one ok result.
   task automatic send_ring();
      logic [63:0] word;
      ctl_mode = CODE_RUNNING;
      if (ring_held == '0) begin
         record_result(ST_OK, 1'b0, '0, 1'b0, 1'b1);
      end else begin
         while (ring_held != '0) begin
            word      = ring_words[ring_rd];
            ring_rd   = ring_rd + 1'b1;
            ring_held = ring_held - 1'b1;
            record_result(ST_OK, 1'b1, word, 1'b0, ring_held == '0);
         end
      end
   endtask

   task automatic stage_command(input req_type rq);
      logic [31:0] lead;
      logic [2:0]  st;
      bit          posted;
      st     = ST_OK;
      posted = 1'b0;
      staged_results.delete();
      case (rq.cmd)
         CMD_QUEUE: begin
            if (ctl_mode != CODE_IDLE) begin
               st = ST_INVALID;
            end else if (ring_held == CNT_W'(QUEUE_DEPTH)) begin
               st = ST_FULL;
            end else begin
               ring_words[ring_wr] = rq.payload;
               ring_wr   = ring_wr + 1'b1;
               ring_held = ring_held + 1'b1;
            end
         end
         CMD_ARM: begin
            if (ctl_mode != CODE_IDLE) begin
               st = ST_INVALID;
            end else if (ring_held == '0) begin
               st = ST_EMPTY;
            end else begin
               ctl_mode = CODE_ARMED;
            end
         end
         CMD_START: begin
            if (ctl_mode == CODE_ARMED) begin
               send_ring();
               posted = 1'b1;
            end else begin
               st = ST_INVALID;
            end
         end
         CMD_START_AT: begin
            if (ctl_mode != CODE_ARMED) begin
               st = ST_INVALID;
            end else begin
               // The target is judged by the signed distance from now.
               lead = rq.target_tick - ctl_tick;
               if (lead[31]) begin
                  st = ST_EXPIRED;
               end else if (lead == '0) begin
                  send_ring();
                  posted = 1'b1;
               end else begin
                  timed_start_pending = 1'b1;
                  timed_start_tick    = rq.target_tick;
               end
            end
         end
         CMD_CLEAR: begin
            if (ctl_mode == CODE_RUNNING) begin
               st = ST_INVALID;
            end else begin
               flush_ring();
               if (ctl_mode != CODE_FAULT && ctl_mode != CODE_ESTOP) begin
                  ctl_mode = CODE_IDLE;
               end
            end
         end
         CMD_ESTOP: begin
            flush_ring();
            ctl_mode = CODE_ESTOP;
            record_result(ST_OK, 1'b1, '0, 1'b1, 1'b1);
            posted = 1'b1;
         end
         CMD_CLEAR_FAULT: begin
            if (ctl_mode != CODE_FAULT && ctl_mode != CODE_ESTOP) begin
               st = ST_INVALID;
            end else begin
               flush_ring();
               ctl_mode = CODE_IDLE;
            end
         end
         CMD_MOTION_DONE: begin
            if (ctl_mode == CODE_RUNNING) begin
               ctl_mode = CODE_IDLE;
            end
         end
         CMD_FAULT: begin
            ctl_mode = CODE_FAULT;
         end
         CMD_TICK: begin
            ctl_tick = ctl_tick + 1'b1;
            if (timed_start_pending) begin
               lead = timed_start_tick - ctl_tick;
               if (lead == '0 || lead[31]) begin
                  timed_start_pending = 1'b0;
                  if (ctl_mode == CODE_ARMED) begin
                     send_ring();
                     posted = 1'b1;
                  end else begin
                     st = ST_INVALID;
                  end
               end
            end
         end
         default: begin
            st = ST_INVALID;
         end
      endcase
      if (!posted) begin
         record_result(st, 1'b0, '0, 1'b0, 1'b1);
      end
   endtask

   // -------------------------------------------------------------------------
   // Request driver. A request is presented at a rising edge and held until
   // an edge sees start high with busy low; at that edge the model takes it.
   // Start stays high across back-to-back requests, so it is never lowered
   // and raised within one time step.
   // -------------------------------------------------------------------------
   task automatic issue_request(input req_type rq, input bit typed,
                                input rsp_type want);
      int gap;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         gap   = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= rq;
      do begin
         @(posedge clock);
      end while (busy);
      stage_command(rq);
      // A typed row checks the block against a hand-written value; the model
      // still runs so that its state follows the block.
      if (typed) begin
         awaited_results.push_back(want);
      end else begin
         foreach (staged_results[j]) begin
            awaited_results.push_back(staged_results[j]);
         end
      end
      requests_sent++;
   endtask

   task automatic send_cmd(input logic [3:0] code, input logic [31:0] tgt);
      req_type rq;
      rq.cmd         = code;
      rq.payload     = {$urandom, $urandom};
      rq.target_tick = tgt;
      issue_request(rq, 1'b0, '0);
   endtask

   // Hold the request side quiet until every owed result has come back.
   task automatic settle();
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [3:0] cmd, input logic [63:0] payload,
                          input logic [31:0] target, input bit typed,
                          input rsp_type want);
      step_row_type row;
      row.cmd     = cmd;
      row.payload = payload;
      row.target  = target;
      row.typed   = typed;
      row.want    = want;
      script.push_back(row);
   endtask

   // Most random sequences are well formed: bring the controller back to
   // idle, fill the ring, arm it and start it one of several ways. The rest
   // is noise, any code with any fields, which also breaks sequences apart.
   task automatic run_sequence();
      int          pick;
      int          n;
      int          k;
      logic [31:0] tgt;
      pick = $urandom_range(99);
      if (pick < 20) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            tgt = $urandom_range(1) ? $urandom : ctl_tick + $urandom_range(2);
            send_cmd(4'($urandom_range(15)), tgt);
         end
      end else begin
         case (ctl_mode)
            CODE_RUNNING:          send_cmd(CMD_MOTION_DONE, $urandom);
            CODE_ARMED:            send_cmd(CMD_CLEAR, $urandom);
            CODE_FAULT, CODE_ESTOP: send_cmd(CMD_CLEAR_FAULT, $urandom);
            default: ;
         endcase
         // Now and then fill past the brim to hit the full ring and the
         // longest drain.
         n = ($urandom_range(4) == 0) ? QUEUE_DEPTH + $urandom_range(2)
                                      : $urandom_range(1, 6);
         repeat (n) send_cmd(CMD_QUEUE, $urandom);
         if ($urandom_range(7) == 0) begin
            send_cmd($urandom_range(1) ? CMD_FAULT : CMD_ESTOP, $urandom);
         end
         send_cmd(CMD_ARM, $urandom);
         case ($urandom_range(4))
            0: send_cmd(CMD_START, $urandom);
            1: send_cmd(CMD_START_AT, ctl_tick);
            2: begin
               k = $urandom_range(1, 3);
               send_cmd(CMD_START_AT, ctl_tick + k);
               // Something may get in the way before the target tick, so
               // the firing tick finds the controller no longer armed.
               case ($urandom_range(5))
                  0: send_cmd(CMD_FAULT, $urandom);
                  1: send_cmd(CMD_CLEAR, $urandom);
                  2: begin
                     k = $urandom_range(1, 3);
                     send_cmd(CMD_START_AT, ctl_tick + k);
                  end
                  default: ;
               endcase
               repeat (k) send_cmd(CMD_TICK, $urandom);
            end
            3: begin
               send_cmd(CMD_START_AT, ctl_tick - $urandom_range(1, 3));
               send_cmd(CMD_START, $urandom);
            end
            default: begin
               send_cmd(CMD_START_AT, $urandom);
               send_cmd(CMD_START, $urandom);
            end
         endcase
         if ($urandom_range(3) != 0) begin
            send_cmd(CMD_MOTION_DONE, $urandom);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Result checker. Results cannot be held off, so every strobe is checked
   // at the edge that ends its cycle against the oldest owed result.
   // -------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result with none awaited, got %0h", $time, rsp_item);
            error_count++;
         end else begin
            awaited_head = awaited_results.pop_front();
            compare_field("status", 64'(awaited_head.status),
                          64'(rsp_item.status));
            compare_field("ctrl_state", 64'(awaited_head.ctrl_state),
                          64'(rsp_item.ctrl_state));
            compare_field("queued_count", 64'(awaited_head.queued_count),
                          64'(rsp_item.queued_count));
            compare_field("send_valid", 64'(awaited_head.send_valid),
                          64'(rsp_item.send_valid));
            compare_field("send_payload", awaited_head.send_payload,
                          rsp_item.send_payload);
            compare_field("send_hard_stop", 64'(awaited_head.send_hard_stop),
                          64'(rsp_item.send_hard_stop));
            compare_field("last", 64'(awaited_head.last), 64'(rsp_item.last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus: a directed script first, then three random phases with
   // different amounts of sender idling, each closed by a full drain.
   // -------------------------------------------------------------------------
   initial begin
      rsp_type hard_stop_want;
      req_type rq;
      int      idle_plan [3];
      int      phase_base;
      idle_plan = '{0, 57, 22};

      hard_stop_want = plain_result(ST_OK, CODE_ESTOP, 5'd0);
      hard_stop_want.send_valid     = 1'b1;
      hard_stop_want.send_hard_stop = 1'b1;

      // Refusals from a fresh idle controller, then the field extremes.
      add_row(CMD_ARM, '0, '0, 1'b1, plain_result(ST_EMPTY, CODE_IDLE, 5'd0));
      add_row(CMD_START, '1, '1, 1'b1, plain_result(ST_INVALID, CODE_IDLE, 5'd0));
      add_row(CMD_UNUSED_TOP, '1, '0, 1'b1,
              plain_result(ST_INVALID, CODE_IDLE, 5'd0));
      add_row(CMD_TICK, '0, '1, 1'b1, plain_result(ST_OK, CODE_IDLE, 5'd0));
      add_row(CMD_QUEUE, '1, '0, 1'b1, plain_result(ST_OK, CODE_IDLE, 5'd1));
      add_row(CMD_QUEUE, '0, '1, 1'b1, plain_result(ST_OK, CODE_IDLE, 5'd2));
      add_row(CMD_START_AT, 64'h0123_4567_89AB_CDEF, '1, 1'b1,
              plain_result(ST_INVALID, CODE_IDLE, 5'd2));
      add_row(CMD_ARM, '1, '0, 1'b1, plain_result(ST_OK, CODE_ARMED, 5'd2));
      add_row(CMD_QUEUE, 64'hA5A5_5A5A_F0F0_0F0F, '0, 1'b1,
              plain_result(ST_INVALID, CODE_ARMED, 5'd2));
      // The tick counter stands at one: a target of zero has passed.
      add_row(CMD_START_AT, '0, 32'h0000_0000, 1'b1,
              plain_result(ST_EXPIRED, CODE_ARMED, 5'd2));
      add_row(CMD_START_AT, '0, 32'h7FFF_FFFF, 1'b1,
              plain_result(ST_OK, CODE_ARMED, 5'd2));
      // A later timed start replaces the far target; the second tick fires.
      add_row(CMD_START_AT, '0, 32'd3, 1'b0, '0);
      add_row(CMD_TICK, '0, '0, 1'b0, '0);
      add_row(CMD_TICK, '0, '0, 1'b0, '0);
      add_row(CMD_CLEAR, '0, '0, 1'b1,
              plain_result(ST_INVALID, CODE_RUNNING, 5'd0));
      add_row(CMD_MOTION_DONE, '0, '0, 1'b1,
              plain_result(ST_OK, CODE_IDLE, 5'd0));
      // A timed start that fires after a fault keeps the ring but refuses.
      add_row(CMD_QUEUE, 64'hDEAD_BEEF_0BAD_F00D, '0, 1'b0, '0);
      add_row(CMD_ARM, '0, '0, 1'b0, '0);
      add_row(CMD_START_AT, '0, 32'd5, 1'b0, '0);
      add_row(CMD_FAULT, '0, '0, 1'b1, plain_result(ST_OK, CODE_FAULT, 5'd1));
      add_row(CMD_TICK, '0, '0, 1'b0, '0);
      add_row(CMD_TICK, '0, '0, 1'b1,
              plain_result(ST_INVALID, CODE_FAULT, 5'd1));
      add_row(CMD_CLEAR, '0, '0, 1'b1, plain_result(ST_OK, CODE_FAULT, 5'd0));
      add_row(CMD_ESTOP, '1, '1, 1'b1, hard_stop_want);
      add_row(CMD_CLEAR_FAULT, '0, '0, 1'b1,
              plain_result(ST_OK, CODE_IDLE, 5'd0));
      // An immediate start on an armed ring.
      add_row(CMD_QUEUE, 64'h8000_0000_0000_0001, '0, 1'b0, '0);
      add_row(CMD_ARM, '0, '0, 1'b0, '0);
      add_row(CMD_START, '0, '0, 1'b0, '0);
      add_row(CMD_MOTION_DONE, '0, '0, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         rq.cmd         = script[i].cmd;
         rq.payload     = script[i].payload;
         rq.target_tick = script[i].target;
         issue_request(rq, script[i].typed, script[i].want);
      end
      settle();

      foreach (idle_plan[p]) begin
         sender_idle_pct = idle_plan[p];
         phase_base      = requests_sent;
         while (requests_sent - phase_base < PHASE_ITEMS) run_sequence();
         settle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("armed_command_staging_queue_tb: clean");
      end else begin
         $display("armed_command_staging_queue_tb: errors");
      end
      $finish;
   end

   // Hard stop for a hung handshake or a result that never arrives.
   initial begin
      #(RUN_LIMIT_NS);
      $display("armed_command_staging_queue_tb: errors");
      $finish;
   end

endmodule

[armed_command_staging_queue.f]
src/acsq_pkg.sv
src/acsq_ram.sv
src/acsq_front.sv
src/acsq_job_fifo.sv
src/acsq_back.sv
src/armed_command_staging_queue.sv
tb/armed_command_staging_queue_tb.sv
